// File: src/pffa_pkg.sv
// ============================================================================
// pffa_pkg
// Shared widths, codes and types of the page frame free list allocator.
// ============================================================================
package pffa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int LINK_W     = IDX_W + 1;

    localparam int FRAME_W    = 36;
    localparam int TAG_W      = 32;
    localparam int COUNT_W    = 13;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAME_W;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4096);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_RELEASE = OP_W'(1);
    localparam logic [OP_W-1:0] OP_QUERY   = OP_W'(2);

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_OOM         = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_UNMANAGED   = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = STATUS_W'(3);

    // classified command between front and back
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             managed;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    // one frame entry of the frame table
    typedef struct packed {
        logic              mark;
        logic [TAG_W-1:0]  gen;
        logic [LINK_W-1:0] link;
    } entry_t;

    // configuration as seen by front and back
    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [LINK_W-1:0]  live;
    } ctx_t;

endpackage

// File: src/pffa_ram.sv
// ============================================================================
// pffa_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module pffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pffa_front.sv
// ============================================================================
// pffa_front
// Input side: takes a transfer and classifies it into a queued command.
// ============================================================================
module pffa_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [pffa_pkg::OP_W-1:0]    operation,
    input  logic [pffa_pkg::FRAME_W-1:0] frame,
    input  logic [pffa_pkg::TAG_W-1:0]   tag,
    input  pffa_pkg::ctx_t           ctx,
    input  logic                     queue_full,
    input  logic                     clearing,
    output logic                     push,
    output pffa_pkg::cmd_t           cmd
);
    import pffa_pkg::*;

    logic [FRAME_W:0] offset;
    logic             managed;

    // borrow out of the top bit means the frame sits below the range
    assign offset  = {1'b0, frame} - {1'b0, ctx.base};
    assign managed = !offset[FRAME_W] && (offset[FRAME_W-1:0] < FRAME_W'(ctx.live));

    assign in_ready = !queue_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cmd.op      = operation;
        cmd.managed = managed;
        cmd.idx     = offset[IDX_W-1:0];
        cmd.tag     = tag;
    end

endmodule

// File: src/pffa_queue.sv
// ============================================================================
// pffa_queue
// Two-entry command queue between front and back.
// ============================================================================
module pffa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pffa_pkg::cmd_t push_data,
    input  logic           pop,
    output pffa_pkg::cmd_t pop_data,
    output logic           full,
    output logic           empty
);
    import pffa_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full command queue");

endmodule

// File: src/pffa_back.sv
// ============================================================================
// pffa_back
// Execution side: clearing pass, frame table access and result register.
// ============================================================================
module pffa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          init_req,
    input  pffa_pkg::ctx_t                ctx,
    input  logic                          q_empty,
    input  pffa_pkg::cmd_t                q_data,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pffa_pkg::STATUS_W-1:0] status,
    output logic [pffa_pkg::FRAME_W-1:0]  result_frame,
    output logic [pffa_pkg::TAG_W-1:0]    result_tag,
    output logic                          is_allocated,
    output logic [pffa_pkg::COUNT_W-1:0]  free_frames
);
    import pffa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clear_idx_reg;
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] free_reg;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  addr_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FRAME_W-1:0]  rframe_reg;
    logic [TAG_W-1:0]    rtag_reg;
    logic                isal_reg;

    entry_t              rd;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;

    logic                fire;
    logic                out_valid_next;
    logic                alloc_ok;
    logic [TAG_W-1:0]    gen_inc;
    logic [TAG_W-1:0]    gen_new;
    logic [STATUS_W-1:0] status_next;
    logic [FRAME_W-1:0]  rframe_next;
    logic [TAG_W-1:0]    rtag_next;
    logic                isal_next;
    logic [LINK_W-1:0]   head_next;
    logic [LINK_W-1:0]   free_next;

    pffa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign clearing = (state_reg == S_CLEAR);

    // load a new result on fire, hold a waiting one until its transfer
    assign out_valid_next = (fire && !init_req) || (out_valid_reg && !out_ready);

    // tag never wraps to zero
    assign gen_inc = rd.gen + TAG_W'(1);
    assign gen_new = (gen_inc == '0) ? TAG_W'(1) : gen_inc;

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = rd;
        ram_re      = 1'b0;
        ram_raddr   = (q_data.op == OP_ALLOC) ? head_reg[IDX_W-1:0] : q_data.idx;
        status_next = ST_OK;
        rframe_next = '0;
        rtag_next   = '0;
        isal_next   = 1'b0;
        head_next   = head_reg;
        free_next   = free_reg;
        alloc_ok    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = clear_idx_reg;
                ram_wdata.mark = 1'b0;
                ram_wdata.gen  = '0;
                ram_wdata.link = LINK_W'(clear_idx_reg) + LINK_W'(1);
            end
            S_IDLE:
            begin
                ram_re = !q_empty;
            end
            S_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_ALLOC:
                    begin
                        if (free_reg == '0 || head_reg >= ctx.live)
                        begin
                            status_next = ST_OOM;
                        end
                        else
                        begin
                            alloc_ok       = 1'b1;
                            ram_we         = fire;
                            ram_wdata.mark = 1'b1;
                            ram_wdata.gen  = gen_new;
                            head_next      = rd.link;
                            free_next      = free_reg - LINK_W'(1);
                            rframe_next    = ctx.base + FRAME_W'(addr_reg);
                            rtag_next      = gen_new;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (!cmd_reg.managed)
                        begin
                            status_next = ST_UNMANAGED;
                        end
                        else if (!rd.mark || rd.gen != cmd_reg.tag)
                        begin
                            status_next = ST_BAD_RELEASE;
                        end
                        else
                        begin
                            ram_we         = fire;
                            ram_wdata.mark = 1'b0;
                            ram_wdata.link = head_reg;
                            head_next      = LINK_W'(cmd_reg.idx);
                            free_next      = free_reg + LINK_W'(1);
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!cmd_reg.managed)
                        begin
                            status_next = ST_UNMANAGED;
                        end
                        else
                        begin
                            isal_next = rd.mark;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_idx_reg <= '0;
            head_reg      <= '0;
            free_reg      <= '0;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            rframe_reg    <= '0;
            rtag_reg      <= '0;
            isal_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (init_req)
            begin
                state_reg     <= S_CLEAR;
                clear_idx_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        if (clear_idx_reg == IDX_W'(MAX_FRAMES - 1))
                        begin
                            head_reg  <= '0;
                            free_reg  <= ctx.live;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            clear_idx_reg <= clear_idx_reg + IDX_W'(1);
                        end
                    end
                    S_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            cmd_reg   <= q_data;
                            addr_reg  <= ram_raddr;
                            state_reg <= S_EXEC;
                        end
                    end
                    S_EXEC:
                    begin
                        // hold here while the previous result waits
                        if (fire)
                        begin
                            head_reg   <= head_next;
                            free_reg   <= free_next;
                            status_reg <= status_next;
                            rframe_reg <= rframe_next;
                            rtag_reg   <= rtag_next;
                            isal_reg   <= isal_next;
                            state_reg  <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_CLEAR;
                    end
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_frame = rframe_reg;
    assign result_tag   = rtag_reg;
    assign is_allocated = isal_reg;
    assign free_frames  = COUNT_W'(free_reg);

    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |-> (free_reg <= ctx.live))
        else $error("free count above managed frame count");

    a_alloc_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && alloc_ok) |-> (ram_we && ram_wdata.gen != '0 && ram_wdata.mark))
        else $error("allocate wrote a zero tag or no allocated mark");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && alloc_ok && !init_req) |=> (free_reg == $past(free_reg) - LINK_W'(1)))
        else $error("free count not decremented by allocate");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != S_IDLE))
        else $error("frame table written while idle");

endmodule

// File: src/page_frame_free_list_allocator_core.sv
// ============================================================================
// page_frame_free_list_allocator_core
// LIFO free list page frame allocator with per-frame generation tags.
// ============================================================================
// Each operation (allocate, release, query) runs in the execution side as a
// frame table read, then the table write and the result register load, which
// wait while a result is held; a two-entry command queue lets new transfers in
// while a result waits. After reset and after every write to base_frame or
// frame_count, a clearing pass rewrites all MAX_FRAMES (4096) table entries,
// and in_ready stays low until it is done.
module page_frame_free_list_allocator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pffa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pffa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pffa_pkg::OP_W-1:0]        operation,
    input  logic [pffa_pkg::FRAME_W-1:0]     frame,
    input  logic [pffa_pkg::TAG_W-1:0]       tag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pffa_pkg::STATUS_W-1:0]    status,
    output logic [pffa_pkg::FRAME_W-1:0]     result_frame,
    output logic [pffa_pkg::TAG_W-1:0]       result_tag,
    output logic                             is_allocated,
    output logic [pffa_pkg::COUNT_W-1:0]     free_frames
);
    import pffa_pkg::*;

    localparam int WIDE_W = FRAME_W + 1;
    localparam logic [WIDE_W-1:0] MAX_WIDE   = WIDE_W'(MAX_FRAMES);
    localparam logic [WIDE_W-1:0] SPACE_WIDE = WIDE_W'(1) << FRAME_W;

    logic [FRAME_W-1:0] base_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LINK_W-1:0]  live_reg;
    logic               init_req;

    logic [WIDE_W-1:0]  room;
    logic [WIDE_W-1:0]  clip_a;
    logic [WIDE_W-1:0]  clip_b;

    ctx_t ctx;
    cmd_t push_cmd;
    cmd_t q_data;
    logic push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clearing;

    assign init_req = cfg_we && (cfg_index == CFG_BASE || cfg_index == CFG_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= FRAME_COUNT_RESET;
            live_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_BASE)
            begin
                base_reg <= cfg_data[FRAME_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            // settles long before the clearing pass ends
            live_reg <= LINK_W'(clip_b);
        end
    end

    // clip count to the built depth and to the top of the frame space
    always_comb
    begin
        room   = SPACE_WIDE - {1'b0, base_reg};
        clip_a = (WIDE_W'(count_reg) > MAX_WIDE) ? MAX_WIDE : WIDE_W'(count_reg);
        clip_b = (clip_a > room) ? room : clip_a;
    end

    always_comb
    begin
        ctx.base = base_reg;
        ctx.live = live_reg;
    end

    pffa_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .frame      (frame),
        .tag        (tag),
        .ctx        (ctx),
        .queue_full (q_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (push_cmd)
    );

    pffa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    pffa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .init_req     (init_req),
        .ctx          (ctx),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_frame (result_frame),
        .result_tag   (result_tag),
        .is_allocated (is_allocated),
        .free_frames  (free_frames)
    );

endmodule

// File: sim/page_frame_free_list_allocator_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// page_frame_free_list_allocator_core_tb
// Self-checking bench for the LIFO page frame allocator.
// ============================================================================
// A scoreboard object mirrors the free list, marks and generation tags and
// predicts one reply per accepted request; replies are compared in order.
// Directed requests cover allocate, release and query corner cases, a range
// at the top of the frame space and an empty range; random phases then churn
// ranges of many sizes with random idle gaps on both channels.
module page_frame_free_list_allocator_core_tb;
    import pffa_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE    = OP_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_NONE    = CFG_IDX_W'(2);
    localparam logic [FRAME_W-1:0]   FRAME_TOP   = '1;
    localparam int                   STALL_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [TAG_W-1:0]    tag;
        logic                alloc;
        logic [COUNT_W-1:0]  free;
    } reply_t;

    class frame_ledger;
        logic [FRAME_W-1:0] base;
        logic [COUNT_W-1:0] count;
        int                 live;
        int                 head;
        int                 free_total;
        int                 errors;
        bit                 mark [MAX_FRAMES];
        logic [TAG_W-1:0]   gen [MAX_FRAMES];
        int                 link [MAX_FRAMES];
        reply_t             pending [$];

        function new();
            base   = '0;
            count  = FRAME_COUNT_RESET;
            errors = 0;
            rebuild();
        endfunction

        // clip to the built depth and to the frames left above base
        function void rebuild();
            logic [FRAME_W:0] room;
            room = {1'b1, {FRAME_W{1'b0}}} - {1'b0, base};
            live = count;
            if (live > MAX_FRAMES)
                live = MAX_FRAMES;
            if (live > room)
                live = int'(room);
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                mark[i] = 1'b0;
                gen[i]  = '0;
                link[i] = i + 1;
            end
            head       = 0;
            free_total = live;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BASE)
                base = data[FRAME_W-1:0];
            else if (idx == CFG_COUNT)
                count = data[COUNT_W-1:0];
            else
                return;
            rebuild();
        endfunction

        function bit locate(logic [FRAME_W-1:0] frm, output int idx);
            logic [FRAME_W-1:0] off;
            idx = 0;
            if (frm < base)
                return 1'b0;
            off = frm - base;
            if (off >= live)
                return 1'b0;
            idx = int'(off);
            return 1'b1;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frm,
                                   logic [TAG_W-1:0] tg);
            reply_t           r;
            int               idx;
            logic [TAG_W-1:0] g;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ALLOC:
                begin
                    idx = head;
                    if (free_total == 0 || idx >= live)
                        r.status = ST_OOM;
                    else
                    begin
                        g = gen[idx] + 1;
                        if (g == '0)
                            g = 1;
                        head = link[idx];
                        free_total--;
                        gen[idx]  = g;
                        mark[idx] = 1'b1;
                        r.frame   = base + FRAME_W'(idx);
                        r.tag     = g;
                    end
                end
                OP_RELEASE:
                begin
                    if (!locate(frm, idx))
                        r.status = ST_UNMANAGED;
                    else if (!mark[idx] || gen[idx] != tg)
                        r.status = ST_BAD_RELEASE;
                    else
                    begin
                        mark[idx] = 1'b0;
                        link[idx] = head;
                        head      = idx;
                        free_total++;
                    end
                end
                OP_QUERY:
                begin
                    if (!locate(frm, idx))
                        r.status = ST_UNMANAGED;
                    else
                        r.alloc = mark[idx];
                end
                default: ;
            endcase
            r.free = COUNT_W'(free_total);
            pending.push_back(r);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t reply with nothing outstanding: status %0d free %0d",
                             $realtime, got.status, got.free);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.frame !== want.frame)
                flag("result_frame", want.frame, got.frame);
            if (got.tag !== want.tag)
                flag("result_tag", want.tag, got.tag);
            if (got.alloc !== want.alloc)
                flag("is_allocated", want.alloc, got.alloc);
            if (got.free !== want.free)
                flag("free_frames", want.free, got.free);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function bit pick_allocated(output logic [FRAME_W-1:0] frm, output logic [TAG_W-1:0] tg);
            int start;
            int i;
            frm = '0;
            tg  = '0;
            if (live == 0)
                return 1'b0;
            start = $urandom_range(0, live - 1);
            for (int k = 0; k < live; k++)
            begin
                i = (start + k) % live;
                if (mark[i])
                begin
                    frm = base + FRAME_W'(i);
                    tg  = gen[i];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [FRAME_W-1:0] pick_managed();
            if (live == 0)
                return base;
            return base + FRAME_W'($urandom_range(0, live - 1));
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation    = '0;
    logic [FRAME_W-1:0]    frame        = '0;
    logic [TAG_W-1:0]      tag          = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [FRAME_W-1:0]    result_frame;
    logic [TAG_W-1:0]      result_tag;
    logic                  is_allocated;
    logic [COUNT_W-1:0]    free_frames;

    bit                    no_idle      = 1'b0;
    int                    quiet_cycles = 0;
    frame_ledger           ledger       = new();

    page_frame_free_list_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .frame        (frame),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_frame (result_frame),
        .result_tag   (result_tag),
        .is_allocated (is_allocated),
        .free_frames  (free_frames)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                ledger.check_reply({status, result_frame, result_tag, is_allocated, free_frames});
            if (cfg_we)
                ledger.configure(cfg_index, cfg_data);
            if (in_valid && in_ready)
                ledger.note_request(operation, frame, tag);
        end
    end

    // clearing passes count as activity through the register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // result side: random stall, then hold ready until one transfer
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task wait_gap();
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task issue(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frm,
               input logic [TAG_W-1:0] tg);
        operation <= op;
        frame     <= frm;
        tag       <= tg;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task send(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frm,
              input logic [TAG_W-1:0] tg);
        wait_gap();
        issue(op, frm, tg);
    endtask

    // drop valid and wait for every reply to drain
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function logic [FRAME_W-1:0] odd_frame();
        case ($urandom_range(0, 3))
            0:       return ledger.base - 1;
            1:       return ledger.base + FRAME_W'(ledger.live);
            2:       return FRAME_TOP;
            default: return FRAME_W'({$urandom, $urandom});
        endcase
    endfunction

    task churn(input int n, input int alloc_pct);
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frm;
        logic [TAG_W-1:0]   tg;
        logic [TAG_W-1:0]   flip;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            wait_gap();
            roll = $urandom_range(0, 99);
            frm  = odd_frame();
            tg   = $urandom;
            op   = OP_RELEASE;
            if (roll < alloc_pct)
                op = OP_ALLOC;
            else if (roll < alloc_pct + (100 - alloc_pct) * 6 / 10)
            begin
                if (ledger.pick_allocated(frm, tg))
                begin
                    // corrupt the tag now and then
                    if ($urandom_range(0, 7) == 0)
                    begin
                        flip = $urandom | 1;
                        tg   = tg ^ flip;
                    end
                end
                else
                    op = OP_ALLOC;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       frm = ledger.pick_managed();
                    1:       ;
                    2, 3:
                    begin
                        op  = OP_QUERY;
                        frm = ledger.pick_managed();
                    end
                    4:       op = OP_QUERY;
                    default: op = OP_SPARE;
                endcase
            end
            issue(op, frm, tg);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [FRAME_W-1:0] b;
        logic [COUNT_W-1:0] c;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default range: basic allocate / release / query behavior
        send(OP_QUERY, '0, '1);
        send(OP_ALLOC, '0, '0);
        send(OP_QUERY, '0, '0);
        send(OP_RELEASE, '0, TAG_W'(2));
        send(OP_RELEASE, '0, TAG_W'(1));
        send(OP_RELEASE, '0, TAG_W'(1));
        send(OP_ALLOC, '0, '0);
        send(OP_QUERY, FRAME_W'(MAX_FRAMES - 1), '0);
        send(OP_QUERY, FRAME_W'(MAX_FRAMES), '0);
        send(OP_RELEASE, FRAME_TOP, '1);
        send(OP_SPARE, FRAME_TOP, '1);

        // range clipped at the top of the frame space: exhaust it
        settle();
        write_reg(CFG_BASE, CFG_DATA_W'(FRAME_TOP - 3));
        repeat (5) send(OP_ALLOC, '0, '0);
        send(OP_QUERY, FRAME_TOP, '0);
        send(OP_RELEASE, FRAME_TOP, TAG_W'(1));
        send(OP_ALLOC, '0, '0);

        // empty range
        settle();
        write_reg(CFG_COUNT, '0);
        send(OP_ALLOC, '0, '0);
        send(OP_RELEASE, FRAME_TOP - 3, '0);
        send(OP_QUERY, FRAME_TOP - 3, '0);

        // full depth, count written with junk above its field
        settle();
        write_reg(CFG_BASE, '0);
        write_reg(CFG_COUNT, CFG_DATA_W'({23'h2AAAAA, 13'h1FFF}));
        churn(350, 70);
        settle();
        write_reg(CFG_NONE, CFG_DATA_W'({$urandom, $urandom}));
        churn(150, 30);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    b = '0;
                    c = COUNT_W'(1);
                end
                1:
                begin
                    b = FRAME_TOP - FRAME_W'($urandom_range(0, 20));
                    c = COUNT_W'(MAX_FRAMES);
                end
                2:
                begin
                    b = FRAME_W'({$urandom, $urandom});
                    c = COUNT_W'(2);
                end
                default:
                begin
                    b = FRAME_W'({$urandom, $urandom});
                    c = COUNT_W'($urandom_range(3, 40));
                end
            endcase
            settle();
            if (p % 2 == 0)
            begin
                write_reg(CFG_BASE, CFG_DATA_W'(b));
                write_reg(CFG_COUNT, CFG_DATA_W'(c));
            end
            else
            begin
                write_reg(CFG_COUNT, CFG_DATA_W'(c));
                write_reg(CFG_BASE, CFG_DATA_W'(b));
            end
            churn(150, $urandom_range(40, 60));
        end

        settle();
        repeat (8) @(posedge clk);
        if (ledger.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
